// ===== rtl/lfid_pkg.sv =====
// Shared constants and codes for the lowest free identifier allocator.
package lfid_pkg;

    localparam int ID_W          = 16;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int DEF_MAP_SIZE  = 1024;

    localparam logic [ID_W-1:0] PID_MIN_RST = 16'd100;
    localparam logic [ID_W-1:0] PID_MAX_RST = 16'd1000;

    // register indexes on the configuration port
    localparam logic REG_PID_MIN = 1'b0;
    localparam logic REG_PID_MAX = 1'b1;

    // request kinds
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

// ===== rtl/lowest_free_id_allocator.sv =====
// Lowest free identifier allocator: in-use bitmap in a word memory, scanned one word a cycle.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in       | in_valid / in_ready    | op, release_id
//  out      | out_valid / out_ready  | granted_id, status
//  cfg      | cfg_we (no wait)       | cfg_idx, cfg_data
//
// Allocate: accept (S_IDLE reads word 0), then S_SCAN examines 32-bit bitmap words
//   in turn through the single memory read port, reading each next word ahead, up
//   to ceil(MAP_SIZE/32) words (32 for the default 1024); S_DONE then hands the
//   result to the output register. An empty span reads no word and skips S_SCAN.
// Release: accept, S_REL_CHK (range check + read), S_REL_WR (write back), S_DONE;
//   out of range identifiers skip S_REL_WR (no read or write back).
// After reset a clearing pass writes zero to every word, during which in_ready
//   stays low; cfg writes are taken as usual.
// A finished result waits in the output register while the next transaction
//   is accepted and worked on; the block stalls only if a second result is
//   ready before the first has been taken.
module lowest_free_id_allocator #(
    parameter int MAP_SIZE = lfid_pkg::DEF_MAP_SIZE
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [lfid_pkg::ID_W-1:0] release_id,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [lfid_pkg::ID_W-1:0] granted_id,
    output logic [1:0]                status,
    // configuration
    input  logic                      cfg_we,
    input  logic                      cfg_idx,
    input  logic [lfid_pkg::ID_W-1:0] cfg_data
);

    localparam int WORD_W    = lfid_pkg::WORD_W;
    localparam int BIT_W     = lfid_pkg::BIT_W;
    localparam int ID_W      = lfid_pkg::ID_W;
    localparam int NUM_WORDS = (MAP_SIZE + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    // wide enough for the span and for any word base address + one word
    localparam int CALC_W    = $clog2(NUM_WORDS * WORD_W + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL_CHK,
        S_REL_WR,
        S_DONE
    } state_t;

    // ---------------- configuration registers ----------------
    logic [ID_W-1:0] pid_min_reg;
    logic [ID_W-1:0] pid_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_min_reg <= lfid_pkg::PID_MIN_RST;
            pid_max_reg <= lfid_pkg::PID_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                lfid_pkg::REG_PID_MIN: pid_min_reg <= cfg_data;
                lfid_pkg::REG_PID_MAX: pid_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // usable span: pid_max - pid_min + 1, clipped to MAP_SIZE, zero if inverted
    logic [ID_W:0]   span_diff;
    logic [ID_W:0]   span_full;
    logic [CALC_W-1:0] span_cur;

    always_comb
    begin
        span_diff = {1'b0, pid_max_reg} - {1'b0, pid_min_reg};
        span_full = span_diff + (ID_W+1)'(1);
        if (pid_max_reg < pid_min_reg)
            span_cur = '0;
        else if (span_full > (ID_W+1)'(MAP_SIZE))
            span_cur = CALC_W'(MAP_SIZE);
        else
            span_cur = CALC_W'(span_full);
    end

    // ---------------- bitmap memory ----------------
    logic [WORD_W-1:0] map_mem [NUM_WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic              mem_we;
    logic [WIDX_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [WIDX_W-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= map_mem[mem_raddr];
    end

    // ---------------- sequencer registers ----------------
    state_t            state_reg,   state_next;
    logic [WIDX_W-1:0] word_reg,    word_next;    // clear / scan / release word
    logic [BIT_W-1:0]  rel_bit_reg, rel_bit_next;
    logic [ID_W-1:0]   rid_reg,     rid_next;
    logic [CALC_W-1:0] span_reg,    span_next;
    logic [ID_W-1:0]   res_id_reg,  res_id_next;
    logic [1:0]        res_st_reg,  res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   granted_id_reg, granted_id_next;
    logic [1:0]        status_reg,  status_next;

    // ---------------- scan datapath (word examiner) ----------------
    logic [CALC_W-1:0] scan_base;
    logic [CALC_W-1:0] next_base;
    logic [CALC_W-1:0] limit;
    logic [WORD_W-1:0] valid_mask;
    logic [WORD_W-1:0] free_bits;
    logic              found;
    logic [BIT_W-1:0]  found_pos;
    logic              last_word;

    always_comb
    begin
        scan_base = CALC_W'({word_reg, {BIT_W{1'b0}}});
        next_base = scan_base + CALC_W'(WORD_W);
        limit     = span_reg - scan_base;
        // bits at or beyond the span count as taken
        if (limit >= CALC_W'(WORD_W))
            valid_mask = '1;
        else
            valid_mask = ~({WORD_W{1'b1}} << limit[BIT_W-1:0]);
        free_bits = ~rdata_reg & valid_mask;
        found     = |free_bits;
        found_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (free_bits[b])
                found_pos = BIT_W'(b);
        end
        last_word = (next_base >= span_reg);
    end

    // ---------------- release range check ----------------
    logic [ID_W-1:0] rel_off;
    logic            rel_ok;

    always_comb
    begin
        rel_off = rid_reg - pid_min_reg;
        rel_ok  = (rid_reg >= pid_min_reg)
               && ({1'b0, rel_off} < (ID_W+1)'(span_reg));
    end

    // ---------------- next-state logic ----------------
    logic in_fire;
    logic out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        rel_bit_next    = rel_bit_reg;
        rid_next        = rid_reg;
        span_next       = span_reg;
        res_id_next     = res_id_reg;
        res_st_next     = res_st_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        granted_id_next = granted_id_reg;
        status_next     = status_reg;

        mem_we    = 1'b0;
        mem_waddr = word_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = word_reg;
                mem_wdata = '0;
                word_next = word_reg + WIDX_W'(1);
                if (word_reg == WIDX_W'(NUM_WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    span_next = span_cur;
                    rid_next  = release_id;
                    word_next = '0;
                    if (op == lfid_pkg::OP_RELEASE)
                        state_next = S_REL_CHK;
                    else if (span_cur == '0)
                    begin
                        res_id_next = '0;
                        res_st_next = lfid_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // rdata_reg holds word word_reg; prefetch the following word
                if (found)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = word_reg;
                    mem_wdata   = rdata_reg | (WORD_W'(1) << found_pos);
                    res_id_next = pid_min_reg + ID_W'({word_reg, found_pos});
                    res_st_next = lfid_pkg::ST_OK;
                    state_next  = S_DONE;
                end
                else if (last_word)
                begin
                    res_id_next = '0;
                    res_st_next = lfid_pkg::ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = word_reg + WIDX_W'(1);
                    word_next = word_reg + WIDX_W'(1);
                end
            end

            S_REL_CHK:
            begin
                res_id_next = '0;
                if (rel_ok)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = rel_off[BIT_W +: WIDX_W];
                    word_next    = rel_off[BIT_W +: WIDX_W];
                    rel_bit_next = rel_off[BIT_W-1:0];
                    state_next   = S_REL_WR;
                end
                else
                begin
                    res_st_next = lfid_pkg::ST_RANGE;
                    state_next  = S_DONE;
                end
            end

            S_REL_WR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = word_reg;
                mem_wdata   = rdata_reg & ~(WORD_W'(1) << rel_bit_reg);
                res_st_next = lfid_pkg::ST_OK;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    granted_id_next = res_id_reg;
                    status_next     = res_st_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- state and registered outputs ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_bit_reg    <= rel_bit_next;
        rid_reg        <= rid_next;
        span_reg       <= span_next;
        res_id_reg     <= res_id_next;
        res_st_reg     <= res_st_next;
        granted_id_reg <= granted_id_next;
        status_reg     <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign granted_id = granted_id_reg;
    assign status     = status_reg;

endmodule

// ===== verif/tb_lowest_free_id_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the lowest free identifier allocator, with a built-in predictor.
module tb_lowest_free_id_allocator;

    localparam int ID_W           = lfid_pkg::ID_W;
    localparam int MAP_SIZE       = lfid_pkg::DEF_MAP_SIZE;
    localparam int HOLD_CYCLES    = 300;   // long output back-pressure stretch
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transaction
    localparam int DRAIN_CYCLES   = 50;    // > worst-case scan latency

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] release_id;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic [1:0]      status;
    } grant_result_t;

    // DUT inputs start at known values
    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            in_valid   = 1'b0;
    logic            op         = lfid_pkg::OP_ALLOC;
    logic [ID_W-1:0] release_id = '0;
    logic            out_ready  = 1'b0;
    logic            cfg_we     = 1'b0;
    logic            cfg_idx    = lfid_pkg::REG_PID_MIN;
    logic [ID_W-1:0] cfg_data   = '0;
    logic            in_ready;
    logic            out_valid;
    logic [ID_W-1:0] granted_id;
    logic [1:0]      status;

    // Predictor state: own copy of the range registers and the in-use bitmap
    logic [ID_W-1:0] pid_lo = lfid_pkg::PID_MIN_RST;
    logic [ID_W-1:0] pid_hi = lfid_pkg::PID_MAX_RST;
    bit              id_in_use [MAP_SIZE];

    request_t        request_backlog [$];   // requests not yet offered to the DUT
    grant_result_t   grant_results_due [$]; // predicted results, oldest first

    // Knobs set per phase by the stimulus process
    bit tx_gaps_on = 1'b0;
    bit rx_gaps_on = 1'b0;
    bit hold_go    = 1'b0;   // toggled to request one long receiver hold-off

    // Process-local bookkeeping
    int       tx_gap;
    int       rx_stall;
    int       hold_left;
    bit       hold_seen;
    int       quiet_cycles;
    int       mismatch_count;
    request_t      next_req;
    grant_result_t predicted;
    grant_result_t oldest;

    lowest_free_id_allocator #(
        .MAP_SIZE(MAP_SIZE)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .release_id (release_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .granted_id (granted_id),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of bitmap entries covered by the current range; zero when the
    // range is inverted, never more than the map holds.
    function automatic int usable_entries();
        int n;
        if (pid_hi < pid_lo)
            n = 0;
        else
        begin
            n = int'(pid_hi) - int'(pid_lo) + 1;
            if (n > MAP_SIZE)
                n = MAP_SIZE;
        end
        return n;
    endfunction

    // Applies one request to the predictor state and returns its result.
    function automatic grant_result_t compute_grant_result(logic req_op,
                                                           logic [ID_W-1:0] rid);
        grant_result_t r;
        int            span;
        int            off;
        bit            found;
        span         = usable_entries();
        off          = int'(rid) - int'(pid_lo);
        found        = 1'b0;
        r.granted_id = '0;
        r.status     = lfid_pkg::ST_OK;
        if (req_op == lfid_pkg::OP_ALLOC)
        begin
            // lowest clear bit inside the span wins
            for (int i = 0; i < span; i++)
            begin
                if (!found && !id_in_use[i])
                begin
                    found        = 1'b1;
                    id_in_use[i] = 1'b1;
                    r.granted_id = pid_lo + i[ID_W-1:0];
                end
            end
            if (!found)
                r.status = lfid_pkg::ST_FULL;
        end
        else
        begin
            // out of range releases leave the bitmap alone
            if (rid < pid_lo || rid > pid_hi || off >= span)
                r.status = lfid_pkg::ST_RANGE;
            else
                id_in_use[off] = 1'b0;
        end
        return r;
    endfunction

    // Idle length: mostly short, sometimes longer, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    //--------------------------------------------------------------------
    // Request driver: offers backlog entries, predicts on acceptance.
    // Each output gets at most one nonblocking assignment per edge.
    //--------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            op         <= lfid_pkg::OP_ALLOC;
            release_id <= '0;
            tx_gap     = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted = compute_grant_result(op, release_id);
                grant_results_due.push_back(predicted);
            end
            // a new transaction may be presented once the current one is gone
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    next_req   = request_backlog.pop_front();
                    in_valid   <= 1'b1;
                    op         <= next_req.op;
                    release_id <= next_req.release_id;
                    if (tx_gaps_on && $urandom_range(0, 2) == 0)
                        tx_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------
    // Result receiver: random stalls, plus the long hold-off on request.
    //--------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  = 0;
            hold_left = 0;
            hold_seen = 1'b0;
        end
        else
        begin
            if (hold_go != hold_seen)
            begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else if (rx_gaps_on && $urandom_range(0, 3) == 0)
            begin
                rx_stall = pick_gap() - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what, input grant_result_t exp_r,
                                 input logic [ID_W-1:0] got_id, input logic [1:0] got_st);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected id=%0d status=%0d, got id=%0d status=%0d",
                     $realtime, what, exp_r.granted_id, exp_r.status, got_id, got_st);
    endtask

    //--------------------------------------------------------------------
    // Result monitor: every accepted result against the oldest prediction.
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_results_due.size() == 0)
                note_mismatch("result with nothing pending", '0, granted_id, status);
            else
            begin
                oldest = grant_results_due.pop_front();
                if (granted_id !== oldest.granted_id || status !== oldest.status)
                    note_mismatch("result mismatch", oldest, granted_id, status);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    //--------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------
    task automatic add_request(input logic req_op, input logic [ID_W-1:0] rid);
        request_t r;
        r.op         = req_op;
        r.release_id = rid;
        request_backlog.push_back(r);
    endtask

    // Blocks until every transaction is offered, accepted and answered.
    task automatic wait_idle();
        while (request_backlog.size() != 0 || in_valid || grant_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only called while the DUT is idle, so the predictor
    // copy can follow right away.
    task automatic write_reg(input logic idx, input logic [ID_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        if (idx == lfid_pkg::REG_PID_MIN)
            pid_lo = value;
        else if (idx == lfid_pkg::REG_PID_MAX)
            pid_hi = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly releases near the live range so they hit allocated entries,
    // with the edges just outside; some fully random identifiers.
    task automatic queue_random_requests(input int count, input int alloc_pct);
        int w;
        int v;
        for (int k = 0; k < count; k++)
        begin
            w = usable_entries();
            if ($urandom_range(0, 99) < alloc_pct)
                add_request(lfid_pkg::OP_ALLOC, ID_W'($urandom_range(0, 65535)));
            else if ($urandom_range(0, 99) < 85)
            begin
                v = int'(pid_lo) - 1 + int'($urandom_range(0, w + 1));
                add_request(lfid_pkg::OP_RELEASE, v[ID_W-1:0]);
            end
            else
                add_request(lfid_pkg::OP_RELEASE, ID_W'($urandom_range(0, 65535)));
        end
    endtask

    task automatic run_random_phase(input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi,
                                    input int count, input int alloc_pct,
                                    input bit tx_idle, input bit rx_idle,
                                    input bit long_hold, input bit pause_mid);
        wait_idle();
        write_reg(lfid_pkg::REG_PID_MIN, lo);
        write_reg(lfid_pkg::REG_PID_MAX, hi);
        tx_gaps_on = tx_idle;
        rx_gaps_on = rx_idle;
        if (long_hold)
            hold_go = !hold_go;   // receiver blocks while requests keep coming
        if (pause_mid)
        begin
            queue_random_requests(count / 2, alloc_pct);
            wait_idle();          // sender waits for every outstanding result
            queue_random_requests(count - count / 2, alloc_pct);
        end
        else
            queue_random_requests(count, alloc_pct);
    endtask

    initial
    begin
        mismatch_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset range 100..1000, offered during the clearing pass
        add_request(lfid_pkg::OP_ALLOC, 16'd0);        // 100
        add_request(lfid_pkg::OP_ALLOC, 16'hFFFF);     // 101, release_id ignored
        add_request(lfid_pkg::OP_RELEASE, 16'd100);
        add_request(lfid_pkg::OP_ALLOC, 16'd0);        // lowest again: 100
        add_request(lfid_pkg::OP_RELEASE, 16'd99);     // just below range
        add_request(lfid_pkg::OP_RELEASE, 16'd1001);   // just above range
        add_request(lfid_pkg::OP_RELEASE, 16'd0);
        add_request(lfid_pkg::OP_RELEASE, 16'hFFFF);
        add_request(lfid_pkg::OP_RELEASE, 16'd500);    // already free, still ok
        add_request(lfid_pkg::OP_RELEASE, 16'd101);
        add_request(lfid_pkg::OP_ALLOC, 16'd0);

        // inverted range: nothing usable
        wait_idle();
        write_reg(lfid_pkg::REG_PID_MIN, 16'd10);
        write_reg(lfid_pkg::REG_PID_MAX, 16'd5);
        add_request(lfid_pkg::OP_ALLOC, 16'd0);
        add_request(lfid_pkg::OP_RELEASE, 16'd7);
        add_request(lfid_pkg::OP_RELEASE, 16'd10);

        // full 16-bit range, clipped to the map; old bits keep their index
        wait_idle();
        write_reg(lfid_pkg::REG_PID_MIN, 16'd0);
        write_reg(lfid_pkg::REG_PID_MAX, 16'hFFFF);
        add_request(lfid_pkg::OP_ALLOC, 16'd0);
        add_request(lfid_pkg::OP_RELEASE, 16'd1023);
        add_request(lfid_pkg::OP_RELEASE, 16'd1024);   // past the map
        add_request(lfid_pkg::OP_RELEASE, 16'hFFFF);

        // two-entry range at the top of the identifier space, run it full
        wait_idle();
        write_reg(lfid_pkg::REG_PID_MIN, 16'hFFFE);
        write_reg(lfid_pkg::REG_PID_MAX, 16'hFFFF);
        add_request(lfid_pkg::OP_ALLOC, 16'd0);
        add_request(lfid_pkg::OP_ALLOC, 16'd0);
        add_request(lfid_pkg::OP_ALLOC, 16'd0);        // full
        add_request(lfid_pkg::OP_RELEASE, 16'hFFFF);

        // Random phases over a spread of ranges and idling patterns
        run_random_phase(16'd0,     16'd15,     100, 50, 1'b1, 1'b1, 1'b0, 1'b0);
        run_random_phase(16'd65520, 16'd65535,  100, 50, 1'b0, 1'b0, 1'b1, 1'b0);
        run_random_phase(16'd0,     16'hFFFF,   100, 70, 1'b1, 1'b1, 1'b0, 1'b0);
        run_random_phase(16'd300,   16'd340,    100, 50, 1'b1, 1'b1, 1'b0, 1'b1);
        run_random_phase(16'd1000,  16'd1000,   100, 50, 1'b0, 1'b1, 1'b0, 1'b0);
        run_random_phase(16'd40000, 16'd40063,  100, 55, 1'b1, 1'b0, 1'b0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (grant_results_due.size() != 0)
            note_mismatch("result never arrived", grant_results_due.pop_front(), 'x, 'x);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
